// ===== design/bam_pkg.sv =====
// Shared types, constants and helpers for the bit adjacency matrix core.
package bam_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned DimW     = 7;
  localparam int unsigned RowW     = MaxNodes;

  localparam int unsigned ModeW    = 3;
  localparam int unsigned TdataInW = 24;
  localparam int unsigned TdataOutW = 16;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  localparam logic [DimW-1:0] DimMax     = DimW'(MaxNodes);
  localparam logic [DimW-1:0] StartReset = 7'd64;

  // Register word index, taken from paddr[2]
  localparam logic RegStartRows = 1'b0;
  localparam logic RegStartCols = 1'b1;

  typedef enum logic [ModeW-1:0] {
    ModeConnect    = 3'd0,
    ModeDisconnect = 3'd1,
    ModeTest       = 3'd2,
    ModeFindSink   = 3'd3,
    ModeFindSource = 3'd4,
    ModeConnectAll = 3'd5,
    ModeClearAll   = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StModify,
    StTest,
    StScanRow,
    StScanCol,
    StFill,
    StDone
  } state_e;

  // Input item; source sits in the low bits of tdata
  typedef struct packed {
    logic [IdxW-1:0] search_top;
    logic [IdxW-1:0] sink;
    logic [IdxW-1:0] source;
  } item_t;

  // Result item; connected sits in bit 0
  typedef struct packed {
    logic            range_error;
    logic [IdxW-1:0] found_index;
    logic            found;
    logic            connected;
  } result_t;

  typedef struct packed {
    logic            load;
    logic [DimW-1:0] rows;
    logic [DimW-1:0] cols;
  } dim_load_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [RowW-1:0] wdata;
    logic [IdxW-1:0] raddr;
  } ram_req_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimMax) begin
      r = DimMax;
    end
    return r;
  endfunction

  localparam logic [DimW-1:0] DimReset = 7'd64;

endpackage

// ===== design/bam_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bam_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/bam_engine.sv =====
// Sequencer and shared scan unit: walks rows or bits, edits rows, builds results.
module bam_engine import bam_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mode_e           in_mode_i,
  input  item_t           in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output result_t         out_res_o,
  input  dim_load_t       dim_load_i,
  output ram_req_t        ram_req_o,
  input  logic [RowW-1:0] ram_rdata_i
);

  state_e          state_q, state_d;
  mode_e           mode_q, mode_d;
  item_t           item_q, item_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] rd_row_q;
  logic [DimW-1:0] rows_q, rows_d;
  logic [DimW-1:0] cols_q, cols_d;
  logic [RowW-1:0] vld_q, vld_d;
  result_t         res_q, res_d;
  result_t         out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic [RowW-1:0] row_data;
  logic [RowW-1:0] bit_mask;
  logic [RowW-1:0] col_mask;
  logic [DimW-1:0] src_ext, snk_ext, top_ext;
  logic            rerr;

  // Rows never written since the last clear read as zero
  assign row_data = vld_q[rd_row_q] ? ram_rdata_i : '0;
  assign bit_mask = RowW'(1) << item_q.sink;
  assign col_mask = {RowW{1'b1}} >> (DimMax - cols_q);

  assign src_ext = {1'b0, in_item_i.source};
  assign snk_ext = {1'b0, in_item_i.sink};
  assign top_ext = {1'b0, in_item_i.search_top};

  always_comb begin
    rerr = 1'b0;
    case (in_mode_i)
      ModeTest:       rerr = (src_ext >= rows_q) || (snk_ext >= cols_q);
      ModeFindSink:   rerr = (src_ext >= rows_q) || (top_ext >= cols_q);
      ModeFindSource: rerr = (snk_ext >= cols_q) || (top_ext >= rows_q);
      default:        rerr = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    item_d      = item_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    rows_d      = rows_q;
    cols_d      = cols_q;
    vld_d       = vld_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_req_o       = '0;
    ram_req_o.raddr = item_q.source;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          mode_d = in_mode_i;
          item_d = in_item_i;
          res_d  = '0;
          idx_d  = in_item_i.search_top;
          pend_d = 1'b0;
          if (rerr) begin
            res_d.range_error = 1'b1;
            state_d = StDone;
          end else begin
            case (in_mode_i)
              ModeConnect, ModeDisconnect: begin
                if (src_ext + DimW'(1) > rows_q) rows_d = src_ext + DimW'(1);
                if (snk_ext + DimW'(1) > cols_q) cols_d = snk_ext + DimW'(1);
                state_d = StRead;
              end
              ModeTest, ModeFindSink: state_d = StRead;
              ModeFindSource:         state_d = StScanCol;
              ModeConnectAll: begin
                idx_d   = '0;
                state_d = StFill;
              end
              ModeClearAll: begin
                vld_d   = '0;
                state_d = StDone;
              end
              default: state_d = StDone;
            endcase
          end
        end
      end
      StRead: begin
        case (mode_q)
          ModeConnect, ModeDisconnect: state_d = StModify;
          ModeTest:                    state_d = StTest;
          ModeFindSink:                state_d = StScanRow;
          default:                     state_d = StDone;
        endcase
      end
      StModify: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = item_q.source;
        ram_req_o.wdata = (mode_q == ModeConnect) ? (row_data | bit_mask)
                                                  : (row_data & ~bit_mask);
        vld_d[item_q.source] = 1'b1;
        state_d = StDone;
      end
      StTest: begin
        res_d.connected = row_data[item_q.sink];
        state_d = StDone;
      end
      StScanRow: begin
        // Keep re-reading the row so its data stays on the port
        if (row_data[idx_q]) begin
          res_d.found       = 1'b1;
          res_d.found_index = idx_q;
          state_d = StDone;
        end else if (idx_q == '0) begin
          state_d = StDone;
        end else begin
          idx_d = idx_q - IdxW'(1);
        end
      end
      StScanCol: begin
        // Issue one row a cycle, check the row read on the cycle before
        ram_req_o.raddr = idx_q;
        idx_d  = idx_q - IdxW'(1);
        pend_d = 1'b1;
        if (pend_q && row_data[item_q.sink]) begin
          res_d.found       = 1'b1;
          res_d.found_index = rd_row_q;
          state_d = StDone;
        end else if (pend_q && rd_row_q == '0) begin
          state_d = StDone;
        end
      end
      StFill: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q;
        ram_req_o.wdata = col_mask;
        vld_d[idx_q]    = 1'b1;
        if ({1'b0, idx_q} == rows_q - DimW'(1)) begin
          state_d = StDone;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      StDone: begin
        // Hand over once the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    if (dim_load_i.load) begin
      rows_d = dim_load_i.rows;
      cols_d = dim_load_i.cols;
      vld_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pend_q      <= 1'b0;
      rows_q      <= DimReset;
      cols_q      <= DimReset;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    item_q   <= item_d;
    idx_q    <= idx_d;
    res_q    <= res_d;
    out_q    <= out_d;
    rd_row_q <= ram_req_o.raddr;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// ===== design/bit_adjacency_matrix_core.sv =====
// Connect and disconnect read and rewrite the source row, test checks one bit of it;
//   find sink walks its row's bits and find source the rows, both down from search_top;
//   connect-all fills the active rows; clear-all and range errors go straight to done.
// Throughput: one item at a time; the column scan and the fill walk one memory row per cycle.
// Reset: row valid flags clear at once, so the store reads as zero without a clearing pass;
//   start registers and active counts come up at 64.
// Top level of the bit adjacency matrix core.
module bit_adjacency_matrix_core import bam_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TdataInW-1:0]  s_axis_tdata,  // source[5:0], sink[11:6], search_top[17:12], 0
  input  logic [ModeW-1:0]     s_axis_tuser,  // mode[2:0]
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TdataOutW-1:0] m_axis_tdata,  // connected[0], found[1], found_index[7:2],
                                              // range_error[8], 0
  // Register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrW-1:0]    paddr,
  input  logic [PdataW-1:0]    pwdata,
  output logic [PdataW-1:0]    prdata,
  output logic                 pready
);

  logic [DimW-1:0] start_rows_q, start_rows_d;
  logic [DimW-1:0] start_cols_q, start_cols_d;
  logic            wr_en;
  dim_load_t       dim_load;
  ram_req_t        ram_req;
  logic [RowW-1:0] ram_rdata;
  result_t         res;

  // Register writes complete in the access phase; pready never stalls
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    start_rows_d = start_rows_q;
    start_cols_d = start_cols_q;
    if (wr_en) begin
      case (paddr[2])
        RegStartRows: start_rows_d = pwdata[DimW-1:0];
        RegStartCols: start_cols_d = pwdata[DimW-1:0];
        default:      start_rows_d = start_rows_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_rows_q <= StartReset;
      start_cols_q <= StartReset;
    end else begin
      start_rows_q <= start_rows_d;
      start_cols_q <= start_cols_d;
    end
  end

  always_comb begin
    case (paddr[2])
      RegStartRows: prdata = PdataW'(start_rows_q);
      RegStartCols: prdata = PdataW'(start_cols_q);
      default:      prdata = '0;
    endcase
  end

  // Any register write clears the store and reloads the active counts
  assign dim_load.load = wr_en;
  assign dim_load.rows = clamp_dim(start_rows_d);
  assign dim_load.cols = clamp_dim(start_cols_d);

  bam_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (mode_e'(s_axis_tuser)),
    .in_item_i   (s_axis_tdata[$bits(item_t)-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .dim_load_i  (dim_load),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // One row of edge bits per source
  bam_ram #(
    .Width (RowW),
    .Depth (MaxNodes)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tdata = TdataOutW'(res);

endmodule

// ===== design/bam_checker.sv =====
// Port-level checks for the bit adjacency matrix core, bound to the top level.
module bam_checker import bam_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [TdataOutW-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again while an item is in work");

  a_range_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("range error with nonzero result bits");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[7:2] == 6'd0)
    else $error("found index set without a hit");

endmodule

bind bit_adjacency_matrix_core bam_checker u_bam_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
